### design/mbps_pkg.sv
// shared types and constants for the masked byte pattern scanner
`timescale 1ns / 1ps
package mbps_pkg;

  localparam int unsigned PATTERN_BYTES_DEF = 16;
  localparam int unsigned PAT_REG_BYTES     = 16;
  localparam int unsigned LEN_W             = 5;
  localparam int unsigned SEL_W             = 4;
  localparam int unsigned CFG_IDX_W         = 3;
  localparam int unsigned CFG_DATA_W        = 64;
  localparam int unsigned ADDR_W            = 32;
  localparam int unsigned COUNT_W           = 32;
  localparam int unsigned CARE_W            = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CARE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BASE     = 3'd4;

  typedef logic [7:0] byte_t;
  typedef logic [PAT_REG_BYTES-1:0][7:0] pattern_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

### design/mbps_cell.sv
// one window cell: holds one byte and compares its incoming byte with its pattern byte
`timescale 1ns / 1ps
module mbps_cell
  import mbps_pkg::*;
#(
  parameter int unsigned IDX = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  cell_ctrl_t       ctrl,
  input  byte_t            byte_in,
  input  pattern_t         pattern,
  input  logic [CARE_W-1:0] care,
  input  logic [LEN_W-1:0] eff_len,
  output byte_t            byte_out,
  output logic             hit
);

  localparam bit IN_RANGE = (IDX < PAT_REG_BYTES);

  byte_t            window_byte;
  logic             active;
  logic [LEN_W-1:0] sel_wide;
  logic [SEL_W-1:0] sel;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      window_byte <= '0;
    end else if (ctrl.shift) begin
      window_byte <= byte_in;
    end
  end

  // this cell sees pattern byte len-1-IDX once the new byte is in
  assign active   = IN_RANGE && (LEN_W'(IDX) < eff_len);
  assign sel_wide = eff_len - LEN_W'(IDX) - LEN_W'(1);
  assign sel      = sel_wide[SEL_W-1:0];
  assign hit      = !active || !care[sel] || (byte_in == pattern[sel]);
  assign byte_out = window_byte;

endmodule

### design/masked_byte_pattern_scan.sv
// top level of the masked byte pattern scanner
//
// Usage: the bytes of one region stream in on data_byte with in_valid and
// in_ready; last_byte marks the final byte. The block compares a sliding
// window of the newest bytes against a pattern of up to 16 bytes, where
// only bytes whose care_mask bit is set are compared. The first window that
// lies wholly inside the region and matches gives one beat on the output
// channel with found=1 and match_address = base_address + start offset; the
// rest of the region is then swallowed. A region that ends without a match
// gives one beat with found=0 and match_address=0.
// Throughput is one byte per cycle while no result beat stalls: the row of
// window cells shifts and all cells compare in parallel in the cycle a byte
// is taken, and its result beat is in the output register the cycle after.
// When the receiver stalls a waiting result, in_ready drops until the beat
// is taken. Configuration writes (index, data) are always accepted and are
// meant to happen between regions. Synchronous reset clears the window,
// the byte count and the output valid flag and loads the register defaults.
`timescale 1ns / 1ps
module masked_byte_pattern_scan
  import mbps_pkg::*;
#(
  parameter int unsigned PATTERN_BYTES = PATTERN_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            data_byte,
  input  logic                  last_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  found,
  output logic [ADDR_W-1:0]     match_address,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned MAX_LEN =
    (PATTERN_BYTES < PAT_REG_BYTES) ? PATTERN_BYTES : PAT_REG_BYTES;

  logic [CFG_DATA_W-1:0] pat_low;
  logic [CFG_DATA_W-1:0] pat_high;
  logic [CARE_W-1:0]     care_mask;
  logic [LEN_W-1:0]      pattern_length;
  logic [ADDR_W-1:0]     base_address;

  logic [COUNT_W-1:0]    byte_count;
  logic [COUNT_W-1:0]    byte_count_next;
  logic                  match_done;

  pattern_t              pattern;
  logic [LEN_W-1:0]      eff_len;
  cell_ctrl_t            ctrl;
  logic                  accept;
  byte_t                 chain [PATTERN_BYTES+1];
  logic [PATTERN_BYTES-1:0] hits;
  logic                  full_window;
  logic                  hit;
  logic                  miss_end;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_low        <= '0;
      pat_high       <= '0;
      care_mask      <= '1;
      pattern_length <= LEN_W'(1);
      base_address   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PAT_LOW:  pat_low        <= cfg_data;
        REG_PAT_HIGH: pat_high       <= cfg_data;
        REG_CARE:     care_mask      <= cfg_data[CARE_W-1:0];
        REG_LENGTH:   pattern_length <= cfg_data[LEN_W-1:0];
        REG_BASE:     base_address   <= cfg_data[ADDR_W-1:0];
        default:      ;
      endcase
    end
  end

  assign pattern = {pat_high, pat_low};

  always_comb begin
    priority if (pattern_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (pattern_length > LEN_W'(MAX_LEN)) begin
      eff_len = LEN_W'(MAX_LEN);
    end else begin
      eff_len = pattern_length;
    end
  end

  assign in_ready   = !out_valid || out_ready;
  assign accept     = in_valid && in_ready;
  assign ctrl.shift = accept && !match_done;
  assign ctrl.clear = accept && last_byte;

  assign chain[0] = data_byte;

  for (genvar i = 0; i < PATTERN_BYTES; i++) begin : g_cell
    mbps_cell #(
      .IDX(i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .byte_in (chain[i]),
      .pattern (pattern),
      .care    (care_mask),
      .eff_len (eff_len),
      .byte_out(chain[i+1]),
      .hit     (hits[i])
    );
  end

  // the last cell's byte falls off the end of the row
  logic unused_tail;
  assign unused_tail = ^chain[PATTERN_BYTES];

  assign byte_count_next = (byte_count == '1) ? byte_count : byte_count + COUNT_W'(1);
  assign full_window     = byte_count_next >= COUNT_W'(eff_len);
  assign hit             = !match_done && full_window && (&hits);
  assign miss_end        = !match_done && last_byte && !hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      match_done <= 1'b0;
    end else if (accept) begin
      if (last_byte) begin
        byte_count <= '0;
        match_done <= 1'b0;
      end else if (!match_done) begin
        byte_count <= byte_count_next;
        match_done <= hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= hit || miss_end;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      found         <= hit;
      match_address <= hit ? base_address + byte_count_next - ADDR_W'(eff_len) : '0;
    end
  end

`ifndef NO_ASSERTIONS
  a_miss_addr_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> match_address == '0)
    else $error("not-found beat with nonzero address");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result beat stalled");

  a_rearm_on_last: assert property (@(posedge clk) disable iff (rst)
    accept && last_byte |=> byte_count == '0 && !match_done)
    else $error("region end did not rearm");

  a_done_gives_found: assert property (@(posedge clk) disable iff (rst)
    $rose(match_done) |-> out_valid && found)
    else $error("match recorded without found beat");

  a_quiet_after_match: assert property (@(posedge clk) disable iff (rst)
    accept && match_done && !last_byte |=> !out_valid)
    else $error("beat produced after match in same region");
`endif

endmodule

### sim/masked_byte_pattern_scan_test.sv
// self-checking testbench for the masked byte pattern scanner
`timescale 1ns / 1ps
module masked_byte_pattern_scan_test;
  import mbps_pkg::*;

  localparam int unsigned WIN_BYTES   = PATTERN_BYTES_DEF;
  localparam int unsigned REG_IDX_TOP = (1 << CFG_IDX_W) - 1;
  localparam int unsigned LONG_HOLD   = 80;
  localparam int unsigned ITEM_BUDGET = 1650;
  localparam int unsigned QUIET_FROM  = 1350;
  localparam int unsigned PRINT_CAP   = 100;

  typedef struct packed {
    byte_t data;
    logic  last;
    logic  drain;
  } scan_beat_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] addr;
  } scan_outcome_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            data_byte = '0;
  logic                  last_byte = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  found;
  logic [ADDR_W-1:0]     match_address;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  masked_byte_pattern_scan dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .last_byte     (last_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .found         (found),
    .match_address (match_address),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // register mirror, reset values
  logic [CFG_DATA_W-1:0] cfg_pat_lo = '0;
  logic [CFG_DATA_W-1:0] cfg_pat_hi = '0;
  logic [CARE_W-1:0]     cfg_care   = '1;
  logic [LEN_W-1:0]      cfg_len    = LEN_W'(1);
  logic [ADDR_W-1:0]     cfg_base   = '0;

  // scanner state copy
  byte_t                 win_bytes [WIN_BYTES];
  logic [COUNT_W-1:0]    win_count = '0;
  logic                  win_done  = 1'b0;

  scan_beat_t    region_bytes_q [$];
  scan_outcome_t scan_outcomes_q [$];
  scan_beat_t    beat_now;
  scan_outcome_t seen;

  int  bytes_queued = 0;
  int  bytes_offered = 0;
  int  bytes_taken = 0;
  int  regions_done = 0;
  int  hits_expected = 0;
  int  misses_expected = 0;
  int  cfg_writes = 0;
  int  mismatches = 0;
  int  phase_no = 0;
  int  idle_pct = 20;
  int  send_gap = 0;
  int  recv_gap = 0;
  int  recv_hold = 0;
  int  hold_requests = 0;
  int  hold_served = 0;
  bit  offer_open = 1'b0;
  bit  quiet = 1'b0;

  initial foreach (win_bytes[i]) win_bytes[i] = '0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic flag_mismatch(input string what);
    if (mismatches < PRINT_CAP)
      $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic predict_scan(input byte_t data, input logic last);
    int unsigned             len;
    logic                    hit;
    logic [2*CFG_DATA_W-1:0] pat;
    scan_outcome_t           res;
    if (!win_done) begin
      len = (cfg_len == 0) ? 1 : cfg_len;
      if (len > PAT_REG_BYTES) len = PAT_REG_BYTES;
      if (len > WIN_BYTES) len = WIN_BYTES;
      for (int i = WIN_BYTES - 1; i > 0; i--) win_bytes[i] = win_bytes[i-1];
      win_bytes[0] = data;
      if (win_count != '1) win_count++;
      hit = 1'b0;
      // only whole windows inside the region are compared
      if (win_count >= len) begin
        hit = 1'b1;
        pat = {cfg_pat_hi, cfg_pat_lo};
        for (int k = 0; k < len; k++)
          if (cfg_care[k] && win_bytes[len-1-k] != pat[8*k +: 8]) hit = 1'b0;
      end
      if (hit) begin
        win_done = 1'b1;
        res.found = 1'b1;
        res.addr = cfg_base + win_count - ADDR_W'(len);
        scan_outcomes_q.push_back(res);
        hits_expected++;
      end else if (last) begin
        res.found = 1'b0;
        res.addr = '0;
        scan_outcomes_q.push_back(res);
        misses_expected++;
      end
    end
    if (last) begin
      foreach (win_bytes[i]) win_bytes[i] = '0;
      win_count = '0;
      win_done = 1'b0;
      regions_done++;
    end
  endtask

  // monitor: mirror config, predict on input beats, check output beats
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PAT_LOW:  cfg_pat_lo = cfg_data;
          REG_PAT_HIGH: cfg_pat_hi = cfg_data;
          REG_CARE:     cfg_care = cfg_data[CARE_W-1:0];
          REG_LENGTH:   cfg_len = cfg_data[LEN_W-1:0];
          REG_BASE:     cfg_base = cfg_data[ADDR_W-1:0];
          default: ;
        endcase
        cfg_writes++;
      end
      if (in_valid && in_ready) begin
        predict_scan(data_byte, last_byte);
        bytes_taken++;
      end
      if (out_valid && out_ready) begin
        if (scan_outcomes_q.size() == 0) begin
          flag_mismatch($sformatf("result beat found=%b addr=%h with nothing expected",
                                  found, match_address));
        end else begin
          seen = scan_outcomes_q.pop_front();
          if (found !== seen.found)
            flag_mismatch($sformatf("found %b, expected %b", found, seen.found));
          if (match_address !== seen.addr)
            flag_mismatch($sformatf("match_address %h, expected %h", match_address, seen.addr));
        end
      end
    end
  end

  // byte driver
  always @(negedge clk) begin
    if (!rst) begin
      if (offer_open && bytes_offered == bytes_taken) begin
        offer_open = 1'b0;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
          send_gap = $urandom_range(1, 12);
      end
      if (!offer_open) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (region_bytes_q.size() != 0 &&
                     (!region_bytes_q[0].drain || scan_outcomes_q.size() == 0)) begin
          beat_now = region_bytes_q.pop_front();
          data_byte <= beat_now.data;
          last_byte <= beat_now.last;
          offer_open = 1'b1;
          bytes_offered++;
        end
      end
      in_valid <= offer_open;
    end
  end

  // result receiver with random stalls and one long hold-off on request
  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      recv_hold = LONG_HOLD;
    end
    if (recv_hold != 0) begin
      recv_hold--;
      out_ready <= 1'b0;
    end else if (recv_gap != 0) begin
      recv_gap--;
      out_ready <= 1'b0;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      recv_gap = $urandom_range(0, 11);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic push_byte(input byte_t data, input logic last, input logic drain);
    scan_beat_t b;
    b.data = data;
    b.last = last;
    b.drain = drain;
    region_bytes_q.push_back(b);
    bytes_queued++;
  endtask

  // block is idle once every byte is taken and every result has come back
  task automatic wait_idle();
    while (region_bytes_q.size() != 0 || offer_open || scan_outcomes_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic byte_t stray_byte(input logic [2*CFG_DATA_W-1:0] pat, input int eff);
    int sel;
    sel = $urandom_range(0, eff - 1);
    if ($urandom_range(0, 1) == 0) return byte_t'($urandom);
    return pat[8*sel +: 8];
  endfunction

  task automatic run_phase(input int pace, input bit pressure);
    logic [CFG_DATA_W-1:0]   lo, hi, junk;
    logic [CARE_W-1:0]       care;
    logic [LEN_W-1:0]        plen;
    logic [ADDR_W-1:0]       base;
    logic [2*CFG_DATA_W-1:0] pat;
    byte_t                   region [200];
    int                      eff, n, at, k, nregions;
    bit                      embed;
    case ($urandom_range(0, 5))
      0: lo = '0;
      1: lo = '1;
      default: lo = {$urandom, $urandom};
    endcase
    case ($urandom_range(0, 5))
      0: hi = '0;
      1: hi = '1;
      default: hi = {$urandom, $urandom};
    endcase
    case ($urandom_range(0, 5))
      0: care = '0;
      1: care = '1;
      2: care = CARE_W'($urandom);
      default: care = CARE_W'($urandom | $urandom);
    endcase
    case ($urandom_range(0, 7))
      0: plen = '0;
      1: plen = LEN_W'(1);
      2: plen = LEN_W'(PAT_REG_BYTES);
      3: plen = LEN_W'($urandom_range(PAT_REG_BYTES + 1, (1 << LEN_W) - 1));
      default: plen = LEN_W'($urandom_range(2, PAT_REG_BYTES));
    endcase
    case ($urandom_range(0, 4))
      0: base = '0;
      1: base = '1;
      2: base = '1 - ADDR_W'($urandom_range(0, 64));
      default: base = $urandom;
    endcase
    // narrow registers sometimes get junk above their width
    junk = {$urandom, $urandom};
    write_reg(REG_PAT_LOW, lo);
    write_reg(REG_PAT_HIGH, hi);
    write_reg(REG_CARE, $urandom_range(0, 1) ? {junk[CFG_DATA_W-1:CARE_W], care}
                                             : CFG_DATA_W'(care));
    write_reg(REG_LENGTH, $urandom_range(0, 1) ? {junk[CFG_DATA_W-1:LEN_W], plen}
                                               : CFG_DATA_W'(plen));
    write_reg(REG_BASE, $urandom_range(0, 1) ? {junk[CFG_DATA_W-1:ADDR_W], base}
                                             : CFG_DATA_W'(base));
    if ($urandom_range(0, 2) == 0)
      write_reg(CFG_IDX_W'($urandom_range(REG_BASE + 1, REG_IDX_TOP)), {$urandom, $urandom});

    eff = (plen == 0) ? 1 : plen;
    if (eff > PAT_REG_BYTES) eff = PAT_REG_BYTES;
    if (eff > WIN_BYTES) eff = WIN_BYTES;
    pat = {hi, lo};
    idle_pct = (quiet || pressure) ? 0 : pace;
    if (pressure) hold_requests++;
    nregions = pressure ? 12 : $urandom_range(4, 10);

    for (int r = 0; r < nregions; r++) begin
      embed = ($urandom_range(0, 9) < 7);
      n = embed ? $urandom_range(eff, eff + 24) : $urandom_range(1, 30);
      if (!pressure && $urandom_range(0, 15) == 0) n = n + $urandom_range(0, 150);
      for (int i = 0; i < n; i++) region[i] = stray_byte(pat, eff);
      if (embed) begin
        at = $urandom_range(0, n - eff);
        for (int j = 0; j < eff; j++)
          if (care[j]) region[at+j] = pat[8*j +: 8];
        // broken sequence: one byte of the planted pattern is spoiled
        if ($urandom_range(0, 4) == 0) begin
          k = $urandom_range(0, eff - 1);
          region[at+k] ^= byte_t'($urandom_range(1, 255));
        end
      end
      for (int i = 0; i < n; i++)
        push_byte(region[i], i == n - 1,
                  i == 0 && ((pressure && r == 3) || $urandom_range(0, 11) == 0));
    end
    wait_idle();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // register defaults: one zero byte pattern
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'h00, 1'b1, 1'b0);
    push_byte(8'hFF, 1'b1, 1'b0);
    wait_idle();

    // zero pattern of three: short region must not match the cleared window
    write_reg(REG_PAT_LOW, '0);
    write_reg(REG_PAT_HIGH, '0);
    write_reg(REG_CARE, '1);
    write_reg(REG_LENGTH, CFG_DATA_W'(3));
    write_reg(REG_BASE, CFG_DATA_W'(32'h0000_1000));
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'h00, 1'b1, 1'b0);
    // match on the third byte, the rest of the region is swallowed
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'h77, 1'b0, 1'b0);
    push_byte(8'h88, 1'b1, 1'b0);
    wait_idle();

    // length zero acts as one, address wraps past the top
    write_reg(REG_LENGTH, '0);
    write_reg(REG_PAT_LOW, CFG_DATA_W'(64'hA5C3_0F96_1E2D_3C5A));
    write_reg(REG_BASE, CFG_DATA_W'(32'hFFFF_FFFF));
    push_byte(8'h11, 1'b0, 1'b0);
    push_byte(8'h5A, 1'b1, 1'b0);
    wait_idle();

    // oversized length saturates, empty care mask matches the first full window
    write_reg(REG_LENGTH, '1);
    write_reg(REG_CARE, '0);
    for (int i = 0; i < PAT_REG_BYTES; i++)
      push_byte(byte_t'($urandom), i == PAT_REG_BYTES - 1, 1'b0);
    wait_idle();

    while (bytes_queued < ITEM_BUDGET) begin
      if (bytes_queued >= QUIET_FROM) quiet = 1'b1;
      case (phase_no % 3)
        0: run_phase(0, phase_no == 2);
        1: run_phase(12, 1'b0);
        default: run_phase(40, phase_no == 2);
      endcase
      phase_no++;
    end
    wait_idle();
    repeat (8) @(posedge clk);

    $display("covered %0d bytes in %0d regions across %0d register settings",
             bytes_taken, regions_done, phase_no + 4);
    $display("checked %0d matches and %0d misses after %0d register writes",
             hits_expected, misses_expected, cfg_writes);
    if (mismatches == 0 && scan_outcomes_q.size() == 0) begin
      $display("masked_byte_pattern_scan regression: pass");
    end else begin
      $display("masked_byte_pattern_scan regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout waiting for the scanner");
    $display("masked_byte_pattern_scan regression: fail");
    $finish;
  end

endmodule

### files.f
design/mbps_pkg.sv
design/mbps_cell.sv
design/masked_byte_pattern_scan.sv
sim/masked_byte_pattern_scan_test.sv
